// ===== src/pth_pkg.sv =====
// Shared types, field widths, level tables and fixed-point constants for the
// pressure-to-height pipeline. Used by every file in src; depends on nothing.
`default_nettype none

package pth_pkg;

	localparam int P_W = 18;
	localparam int T_W = 16;
	localparam int H_W = 22;
	localparam int ST_W = 2;

	localparam int TABLE_LEVELS = 33;
	localparam int SEG_W = $clog2(TABLE_LEVELS);
	localparam int LAPSE_TOP = 22;

	localparam int FRAC = 16;
	localparam int LN_W = 20;
	localparam int R_W = 21;
	localparam int M_W = 32;
	localparam int D_W = 20;
	localparam int TT_W = 24;
	localparam int SUM_W = 21;
	localparam int PROD_W = 45;
	localparam int Q_W = 35;
	localparam int DEN_W = 18;
	localparam int Z_W = 15;
	localparam int HQ_W = 36;
	localparam int HT_W = 26;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_TEMP = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

	localparam logic [T_W-1:0] T_MIN = 16'd15000;
	localparam logic [T_W-1:0] T_MAX = 16'd28815;
	localparam logic [P_W-1:0] P_SURFACE = 18'd101325;
	localparam logic [H_W-1:0] HEIGHT_MAX = 22'd4000000;
	localparam logic [19:0] K_HYPSO = 20'd959637;
	localparam logic [16:0] LAPSE_Q24 = 17'd109052;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [21:0] FT10_Q32 = 22'd2150131;
	localparam logic [27:0] RECIP125 = 28'd137438953;
	localparam logic [SUM_W-1:0] S_LAPSE_OFS = 21'd576300;
	localparam logic [SUM_W-1:0] S_EXTRAP_OFS = 21'd436300;

	localparam logic [P_W-1:0] LVL_PRES [TABLE_LEVELS] = '{
		18'd101325, 18'd95457, 18'd89871, 18'd84550, 18'd79490, 18'd74675,
		18'd70099, 18'd65753, 18'd61629, 18'd57715, 18'd54007, 18'd50490,
		18'd47165, 18'd44020, 18'd41046, 18'd38235, 18'd35582, 18'd33081,
		18'd30724, 18'd28507, 18'd26419, 18'd24458, 18'd23453, 18'd22619,
		18'd19338, 18'd16533, 18'd14135, 18'd12086, 18'd10330, 18'd8834,
		18'd7553, 18'd6457, 18'd5521};

	localparam logic [Z_W-1:0] LVL_Z [TABLE_LEVELS] = '{
		15'd0, 15'd500, 15'd1000, 15'd1500, 15'd2000, 15'd2500, 15'd3000,
		15'd3500, 15'd4000, 15'd4500, 15'd5000, 15'd5500, 15'd6000, 15'd6500,
		15'd7000, 15'd7500, 15'd8000, 15'd8500, 15'd9000, 15'd9500, 15'd10000,
		15'd10500, 15'd10769, 15'd11000, 15'd12000, 15'd13000, 15'd14000,
		15'd15000, 15'd16000, 15'd17000, 15'd18000, 15'd19000, 15'd20000};

	typedef struct packed {
		logic [P_W-1:0] pressure;
		logic [T_W-1:0] temperature;
	} sample_t;

	typedef struct packed {
		logic [H_W-1:0] height;
		logic [ST_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic vld;
		logic kill;
		logic [ST_W-1:0] status;
		logic [SEG_W-1:0] seg;
		logic [T_W-1:0] temp;
	} ctl_t;

	typedef logic [TABLE_LEVELS-1:0][LN_W-1:0] ln_tab_t;

	function automatic logic [LN_W-1:0] ln_q16(input logic [P_W-1:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int n;
		n = 0;
		for (int i = 1; i < P_W; i++) begin
			if (x[i]) begin
				n = i;
			end
		end
		m = 64'(x) << (31 - n);
		r = 64'(n) << FRAC;
		for (int i = FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		r = (r * 64'(LN2_Q30)) >> 30;
		return r[LN_W-1:0];
	endfunction

	function automatic ln_tab_t build_ln_tab();
		ln_tab_t tab;
		for (int k = 0; k < TABLE_LEVELS; k++) begin
			tab[k] = ln_q16(LVL_PRES[k]);
		end
		return tab;
	endfunction

	localparam ln_tab_t LN_BASE = build_ln_tab();

endpackage

`default_nettype wire

// ===== src/pth_log.sv =====
// Pipelined natural logarithm in Q16: normalize, sixteen squaring stages, ln2 scale.
// Depends on pth_pkg for widths and the control struct.
`default_nettype none

module pth_log (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  pth_pkg::ctl_t             ctl_i,
	input  logic [pth_pkg::P_W-1:0]   x_i,
	output pth_pkg::ctl_t             ctl_o,
	output logic [pth_pkg::LN_W-1:0]  ln_o
);

	localparam int PW = pth_pkg::P_W;
	localparam int MW = pth_pkg::M_W;
	localparam int RW = pth_pkg::R_W;
	localparam int LNW = pth_pkg::LN_W;
	localparam int FRAC = pth_pkg::FRAC;
	localparam int NW = $clog2(PW);
	localparam int NS = FRAC;

	logic [NW-1:0] n_c;
	logic [MW-1:0] m0_c;
	logic [RW-1:0] r0_c;
	logic [MW-1:0] m_n [NS];
	logic [RW-1:0] r_n [NS];
	logic [RW+29:0] ln_prod;

	logic [MW-1:0] m_s [NS+1];
	logic [RW-1:0] r_s [NS+1];
	pth_pkg::ctl_t ctl_s [NS+2];
	logic [LNW-1:0] ln_s;

	always_comb begin
		n_c = '0;
		for (int i = 1; i < PW; i++) begin
			if (x_i[i]) begin
				n_c = NW'(i);
			end
		end
		m0_c = MW'(x_i) << (NW'(MW - 1) - n_c);
		r0_c = RW'(n_c) << FRAC;
	end

	always_comb begin
		logic [2*MW-1:0] sq;
		for (int k = 0; k < NS; k++) begin
			sq = (2*MW)'(m_s[k]) * (2*MW)'(m_s[k]);
			r_n[k] = r_s[k];
			if (sq[2*MW-1]) begin
				m_n[k] = sq[2*MW-1:MW];
				r_n[k][FRAC-1-k] = 1'b1;
			end else begin
				m_n[k] = sq[2*MW-2:MW-1];
			end
		end
	end

	assign ln_prod = (RW+30)'(r_s[NS]) * (RW+30)'(pth_pkg::LN2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS + 2; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= ctl_i;
			for (int k = 1; k < NS + 2; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= m0_c;
			r_s[0] <= r0_c;
			for (int k = 0; k < NS; k++) begin
				m_s[k+1] <= m_n[k];
				r_s[k+1] <= r_n[k];
			end
			ln_s <= ln_prod[LNW+29:30];
		end
	end

	assign ctl_o = ctl_s[NS+1];
	assign ln_o = ln_s;

endmodule

`default_nettype wire

// ===== src/pth_div.sv =====
// Pipelined restoring divider computing (q << 16) / den, five quotient bits per stage.
// Depends on pth_pkg; passes q through unchanged for levels that use the isothermal form.
`default_nettype none

module pth_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  pth_pkg::ctl_t              ctl_i,
	input  logic [pth_pkg::Q_W-1:0]    q_i,
	input  logic [pth_pkg::DEN_W-1:0]  den_i,
	output pth_pkg::ctl_t              ctl_o,
	output logic [pth_pkg::Q_W-1:0]    dz_o
);

	localparam int QW = pth_pkg::Q_W;
	localparam int DW = pth_pkg::DEN_W;
	localparam int FRAC = pth_pkg::FRAC;
	localparam int STEP = 5;
	localparam int NST = (QW + STEP - 1) / STEP;

	logic [DW-1:0] src_rem [NST];
	logic [QW-1:0] src_acc [NST];
	logic [DW-1:0] src_den [NST];
	logic [DW-1:0] rem_c [NST];
	logic [QW-1:0] acc_c [NST];

	logic [DW-1:0] rem_s [NST];
	logic [QW-1:0] acc_s [NST];
	logic [DW-1:0] den_s [NST];
	logic [QW-1:0] q_s [NST];
	pth_pkg::ctl_t ctl_s [NST];

	always_comb begin
		src_rem[0] = DW'(q_i[QW-1 -: FRAC]);
		src_acc[0] = {q_i[QW-FRAC-1:0], {FRAC{1'b0}}};
		src_den[0] = den_i;
		for (int k = 1; k < NST; k++) begin
			src_rem[k] = rem_s[k-1];
			src_acc[k] = acc_s[k-1];
			src_den[k] = den_s[k-1];
		end
	end

	always_comb begin
		logic [DW-1:0] rem;
		logic [QW-1:0] acc;
		logic [DW:0] tr;
		for (int k = 0; k < NST; k++) begin
			rem = src_rem[k];
			acc = src_acc[k];
			for (int b = 0; b < STEP; b++) begin
				if (k * STEP + b < QW) begin
					tr = {rem, acc[QW-1]};
					acc = {acc[QW-2:0], 1'b0};
					if (tr >= {1'b0, src_den[k]}) begin
						tr = tr - {1'b0, src_den[k]};
						acc[0] = 1'b1;
					end
					rem = tr[DW-1:0];
				end
			end
			rem_c[k] = rem;
			acc_c[k] = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= ctl_i;
			for (int k = 1; k < NST; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= q_i;
			den_s[0] <= den_i;
			for (int k = 0; k < NST; k++) begin
				rem_s[k] <= rem_c[k];
				acc_s[k] <= acc_c[k];
			end
			for (int k = 1; k < NST; k++) begin
				q_s[k] <= q_s[k-1];
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign ctl_o = ctl_s[NST-1];
	assign dz_o = (ctl_s[NST-1].seg <= pth_pkg::SEG_W'(pth_pkg::LAPSE_TOP)) ?
		acc_s[NST-1] : q_s[NST-1];

endmodule

`default_nettype wire

// ===== src/pressure_to_height_std_atmos_unit.sv =====
// Top level: pressure and temperature in, pressure altitude in 0.1 ft and status out.
// Depends on pth_pkg, pth_log and pth_div.
//
//  channel   dir  handshake                    payload
//  sample    in   sample_valid / sample_ready  pth_pkg::sample_t (pressure, temperature)
//  result    out  result_valid / result_ready  pth_pkg::result_t (height, status)
//
// One request enters per cycle while no stalled result holds the pipeline.
// The depth is set by the sixteen squaring stages of the logarithm and the
// seven stages of the quotient divider.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset clears only the valid bits and control fields; no clearing pass is needed.
`default_nettype none

module pressure_to_height_std_atmos_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  pth_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output pth_pkg::result_t  result
);

	localparam int TL = pth_pkg::TABLE_LEVELS;
	localparam int SEGW = pth_pkg::SEG_W;
	localparam int PW = pth_pkg::P_W;
	localparam int LNW = pth_pkg::LN_W;
	localparam int DWD = pth_pkg::D_W;
	localparam int TTW = pth_pkg::TT_W;
	localparam int SUMW = pth_pkg::SUM_W;
	localparam int PRW = pth_pkg::PROD_W;
	localparam int QW = pth_pkg::Q_W;
	localparam int DENW = pth_pkg::DEN_W;
	localparam int HQW = pth_pkg::HQ_W;
	localparam int HTW = pth_pkg::HT_W;
	localparam int HW = pth_pkg::H_W;
	localparam int FRAC = pth_pkg::FRAC;

	logic en;
	logic [SEGW-1:0] seg_c;
	pth_pkg::ctl_t ctl_c;

	pth_pkg::ctl_t ctl_s1, ctl_lg, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	pth_pkg::ctl_t ctl_dv, ctl_s9, ctl_s10;
	logic [PW-1:0] p_s1;
	logic [LNW-1:0] lp_lg;

	logic [LNW-1:0] lb_c;
	logic [SUMW-1:0] sum_c;
	logic [DWD-1:0] d_s2;
	logic [SUMW-1:0] sum_s2, sum_s3, sum_s4;
	logic [39:0] kd_c;
	logic [TTW-1:0] tt_s3;
	logic [PRW-1:0] prod_c;
	logic [40:0] lap_c;
	logic [PRW-1:0] prod_s4;
	logic [DENW-1:0] den_s4, den_s5, den_s6, den_s7, den_s8;
	logic [40:0] y_s5;
	logic [48:0] qh_mul_c;
	logic [14:0] qhe_s5;
	logic [21:0] rh_c;
	logic [14:0] qh_c, qh_s6, qh_s7;
	logic [26:0] v_c, v_s6, v_s7;
	logic [54:0] ql_mul_c;
	logic [20:0] qle_s7;
	logic [27:0] rl_c;
	logic [19:0] ql_c;
	logic [QW-1:0] q_s8;
	logic [QW-1:0] dz_dv;
	logic [HQW-1:0] h_s9;
	logic [58:0] hs_c;
	logic [HTW-1:0] ht_s10;
	pth_pkg::result_t res_c, res_s11;
	logic vld_s11;

	assign en = !vld_s11 || result_ready;
	assign sample_ready = en;

	always_comb begin
		seg_c = '0;
		for (int j = 1; j < TL; j++) begin
			if (sample.pressure < pth_pkg::LVL_PRES[j]) begin
				seg_c = SEGW'(j);
			end
		end
		ctl_c.vld = sample_valid;
		ctl_c.seg = seg_c;
		ctl_c.temp = sample.temperature;
		ctl_c.kill = 1'b1;
		ctl_c.status = pth_pkg::ST_OK;
		if (sample.temperature < pth_pkg::T_MIN || sample.temperature > pth_pkg::T_MAX) begin
			ctl_c.status = pth_pkg::ST_TEMP;
		end else if (sample.pressure > pth_pkg::P_SURFACE) begin
			ctl_c.status = pth_pkg::ST_OK;
		end else if (sample.pressure == '0) begin
			ctl_c.status = pth_pkg::ST_ZERO;
		end else begin
			ctl_c.kill = 1'b0;
		end
	end

	pth_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_s1),
		.x_i    (p_s1),
		.ctl_o  (ctl_lg),
		.ln_o   (lp_lg)
	);

	always_comb begin
		lb_c = pth_pkg::LN_BASE[ctl_lg.seg];
		sum_c = SUMW'(ctl_lg.temp) * SUMW'(20);
		if (ctl_lg.seg == SEGW'(TL - 1)) begin
			sum_c = sum_c + pth_pkg::S_EXTRAP_OFS;
		end else if (ctl_lg.seg <= SEGW'(pth_pkg::LAPSE_TOP)) begin
			sum_c = sum_c + pth_pkg::S_LAPSE_OFS
				- SUMW'(pth_pkg::LVL_Z[ctl_lg.seg]) * SUMW'(13);
		end else begin
			sum_c = sum_c + pth_pkg::S_LAPSE_OFS;
		end
	end

	assign kd_c = 40'(d_s2) * 40'(pth_pkg::K_HYPSO);
	assign prod_c = PRW'(tt_s3) * PRW'(sum_s3);
	assign lap_c = 41'(tt_s3) * 41'(pth_pkg::LAPSE_Q24);
	assign qh_mul_c = 49'(prod_s4[PRW-1:24]) * 49'(pth_pkg::RECIP125);

	always_comb begin
		rh_c = 22'(y_s5[40:20]) - 22'(qhe_s5) * 22'(125);
		qh_c = qhe_s5;
		if (rh_c >= 22'(125)) begin
			rh_c = rh_c - 22'(125);
			qh_c = qhe_s5 + 15'(1);
		end
		v_c = {rh_c[6:0], y_s5[19:0]};
	end

	assign ql_mul_c = 55'(v_s6) * 55'(pth_pkg::RECIP125);

	always_comb begin
		rl_c = 28'(v_s7) - 28'(qle_s7) * 28'(125);
		ql_c = qle_s7[19:0];
		if (rl_c >= 28'(125)) begin
			ql_c = qle_s7[19:0] + 20'(1);
		end
	end

	pth_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_s8),
		.q_i    (q_s8),
		.den_i  (den_s8),
		.ctl_o  (ctl_dv),
		.dz_o   (dz_dv)
	);

	assign hs_c = 59'(h_s9) * 59'(pth_pkg::FT10_Q32) + (59'(1) << 31);

	always_comb begin
		res_c.status = ctl_s10.status;
		if (ctl_s10.kill) begin
			res_c.height = '0;
		end else if (ht_s10 > HTW'(pth_pkg::HEIGHT_MAX)) begin
			res_c.height = pth_pkg::HEIGHT_MAX;
		end else begin
			res_c.height = ht_s10[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
			ctl_s10 <= '0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_lg;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_dv;
			ctl_s10 <= ctl_s9;
			vld_s11 <= ctl_s10.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= sample.pressure;
			d_s2 <= (lb_c > lp_lg) ? (lb_c - lp_lg) : '0;
			sum_s2 <= sum_c;
			tt_s3 <= kd_c[FRAC+TTW-1:FRAC];
			sum_s3 <= sum_s2;
			prod_s4 <= prod_c;
			sum_s4 <= sum_s3;
			den_s4 <= DENW'(65536) + DENW'(lap_c[40:24]);
			y_s5 <= prod_s4[PRW-1:4];
			qhe_s5 <= qh_mul_c[48:34];
			den_s5 <= den_s4;
			qh_s6 <= qh_c;
			v_s6 <= v_c;
			den_s6 <= den_s5;
			qh_s7 <= qh_s6;
			v_s7 <= v_s6;
			qle_s7 <= ql_mul_c[54:34];
			den_s7 <= den_s6;
			q_s8 <= {qh_s7, ql_c};
			den_s8 <= den_s7;
			h_s9 <= (HQW'(pth_pkg::LVL_Z[ctl_dv.seg]) << FRAC) + HQW'(dz_dv);
			ht_s10 <= hs_c[57:32];
			res_s11 <= res_c;
		end
	end

	assign result_valid = vld_s11;
	assign result = res_s11;

	a_flag_zero_height: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != pth_pkg::ST_OK |-> result.height == '0)
		else $error("nonzero height with an error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == pth_pkg::ST_OK ||
			result.status == pth_pkg::ST_TEMP || result.status == pth_pkg::ST_ZERO))
		else $error("undefined status code");

	a_height_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.height <= pth_pkg::HEIGHT_MAX)
		else $error("height above saturation limit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |=> $stable(q_s8) && $stable(ctl_s8) && $stable(h_s9))
		else $error("pipeline stage moved during a stall");

	a_sum_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.vld && !ctl_s3.kill |-> sum_s3 >= pth_pkg::SUM_W'(436300))
		else $error("temperature sum out of range for a live request");

	// sum_s4 keeps the multiplier operand visible for debug alongside prod_s4.
	a_prod_track: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s3.vld |=> sum_s4 == $past(sum_s3))
		else $error("temperature sum lost between stages");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for pressure_to_height_std_atmos_unit: streams pressure and temperature
// requests and checks each pressure altitude and status against its own predictor.
// Depends on pth_pkg and the RTL of the unit.
`default_nettype none

module testbench;

	localparam int N_RANDOM = 1850;
	localparam int LATENCY = 36;

	localparam logic [31:0] LVL_P [33] = '{
		101325, 95457, 89871, 84550, 79490, 74675, 70099, 65753, 61629, 57715,
		54007, 50490, 47165, 44020, 41046, 38235, 35582, 33081, 30724, 28507,
		26419, 24458, 23453, 22619, 19338, 16533, 14135, 12086, 10330, 8834,
		7553, 6457, 5521};
	localparam logic [31:0] LVL_H [33] = '{
		0, 500, 1000, 1500, 2000, 2500, 3000, 3500, 4000, 4500,
		5000, 5500, 6000, 6500, 7000, 7500, 8000, 8500, 9000, 9500,
		10000, 10500, 10769, 11000, 12000, 13000, 14000, 15000, 16000, 17000,
		18000, 19000, 20000};

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	pth_pkg::sample_t sample;
	logic result_valid;
	logic result_ready;
	pth_pkg::result_t result;

	pth_pkg::sample_t pending_samples[$];
	pth_pkg::result_t expected_heights[$];
	int errors = 0;
	int n_results = 0;
	int n_requests = 0;
	bit stimulus_done = 0;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_off = 0;

	pressure_to_height_std_atmos_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	function automatic logic [63:0] natural_log(input logic [31:0] x);
		int n;
		logic [63:0] m;
		logic [63:0] r;
		n = 0;
		while (n < 31 && (x >> (n + 1)) != 0) begin
			n++;
		end
		m = 64'(x) << (31 - n);
		r = 64'(n) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return (r * 64'd744261118) >> 30;
	endfunction

	function automatic pth_pkg::result_t pressure_altitude(input pth_pkg::sample_t s);
		pth_pkg::result_t res;
		int seg;
		logic [31:0] p;
		logic [31:0] t;
		logic [63:0] lb, lp, d, tt, sm, q, dz, h, den, ht;
		p = 32'(s.pressure);
		t = 32'(s.temperature);
		res.height = '0;
		res.status = pth_pkg::ST_OK;
		if (t < 15000 || t > 28815) begin
			res.status = pth_pkg::ST_TEMP;
		end else if (p > 101325) begin
			res.status = pth_pkg::ST_OK;
		end else if (p == 0) begin
			res.status = pth_pkg::ST_ZERO;
		end else begin
			seg = 32;
			if (p >= LVL_P[32]) begin
				for (int k = 31; k >= 0; k--) begin
					if (p >= LVL_P[k + 1]) begin
						seg = k;
					end
				end
			end
			lb = natural_log(LVL_P[seg]);
			lp = natural_log(p);
			d = (lb > lp) ? lb - lp : 64'd0;
			tt = (64'd959637 * d) >> 16;
			if (seg == 32) begin
				sm = 20 * 64'(t) + 436300;
			end else if (seg <= 22) begin
				sm = 20 * 64'(t) + 576300 - 13 * 64'(LVL_H[seg]);
			end else begin
				sm = 20 * 64'(t) + 576300;
			end
			q = (tt * sm) / 2000;
			if (seg != 32 && seg <= 22) begin
				den = 65536 + ((tt * 64'd109052) >> 24);
				dz = (q * 65536) / den;
			end else begin
				dz = q;
			end
			h = (64'(LVL_H[seg]) << 16) + dz;
			ht = (h * 64'd2150131 + 64'h8000_0000) >> 32;
			if (ht > 4000000) begin
				ht = 4000000;
			end
			res.height = ht[pth_pkg::H_W-1:0];
		end
		return res;
	endfunction

	function automatic pth_pkg::sample_t make_sample(input int p, input int t);
		pth_pkg::sample_t s;
		s.pressure = pth_pkg::P_W'(p);
		s.temperature = pth_pkg::T_W'(t);
		return s;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		int r;
		int lv;
		pending_samples.push_back(make_sample(0, 20000));
		pending_samples.push_back(make_sample(1, 15000));
		pending_samples.push_back(make_sample(1, 28815));
		pending_samples.push_back(make_sample(101325, 28815));
		pending_samples.push_back(make_sample(101326, 20000));
		pending_samples.push_back(make_sample(262143, 65535));
		pending_samples.push_back(make_sample(200000, 0));
		pending_samples.push_back(make_sample(50000, 14999));
		pending_samples.push_back(make_sample(50000, 28816));
		pending_samples.push_back(make_sample(0, 0));
		pending_samples.push_back(make_sample(5521, 21815));
		pending_samples.push_back(make_sample(5520, 21815));
		pending_samples.push_back(make_sample(23453, 21650));
		pending_samples.push_back(make_sample(22619, 21650));
		pending_samples.push_back(make_sample(24458, 22000));
		pending_samples.push_back(make_sample(95457, 28000));
		pending_samples.push_back(make_sample(95456, 28000));
		pending_samples.push_back(make_sample(100, 15000));
		pending_samples.push_back(make_sample(174762, 43690));
		pending_samples.push_back(make_sample(87381, 21845));
		for (int i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				lv = $urandom_range(0, 32);
				pending_samples.push_back(make_sample(
					$urandom_range(LVL_P[lv] > 3 ? LVL_P[lv] - 3 : 1, LVL_P[lv] + 3),
					$urandom_range(15000, 28815)));
			end else if (r < 80) begin
				pending_samples.push_back(make_sample($urandom_range(1, 101325),
					$urandom_range(15000, 28815)));
			end else if (r < 88) begin
				pending_samples.push_back(make_sample($urandom_range(0, 5521),
					$urandom_range(15000, 28815)));
			end else begin
				pending_samples.push_back(make_sample($urandom_range(0, 262143),
					$urandom_range(0, 65535)));
			end
		end
		stimulus_done = 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			send_wait <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_heights.push_back(pressure_altitude(sample));
				n_requests <= n_requests + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample <= pending_samples.pop_front();
					sample_valid <= 1'b1;
					send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pth_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_wait <= 0;
			hold_off <= 0;
		end else begin
			if (result_valid && result_ready) begin
				n_results <= n_results + 1;
				if (expected_heights.size() == 0) begin
					$display("%0t: unexpected result height=%0d status=%0d",
						$time, result.height, result.status);
					errors++;
				end else begin
					want = expected_heights.pop_front();
					if (want.height !== result.height) begin
						$display("%0t: height expected %0d actual %0d",
							$time, want.height, result.height);
						errors++;
					end
					if (want.status !== result.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						errors++;
					end
				end
			end
			if (n_requests == 300 && hold_off == 0) begin
				hold_off <= 200;
				result_ready <= 1'b0;
			end else if (hold_off > 1) begin
				hold_off <= hold_off - 1;
				result_ready <= 1'b0;
			end else if (hold_off == 1) begin
				hold_off <= -1;
				result_ready <= 1'b1;
			end else if (result_valid && result_ready || !result_ready) begin
				if (recv_wait > 0) begin
					recv_wait <= recv_wait - 1;
					result_ready <= 1'b0;
				end else begin
					result_ready <= 1'b1;
					recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
				end
			end
		end
	end

	initial begin
		wait (stimulus_done && pending_samples.size() == 0 && !sample_valid);
		wait (expected_heights.size() == 0);
		repeat (LATENCY * 2) @(posedge clk);
		if (expected_heights.size() != 0) begin
			errors++;
		end
		$display("Checked %0d results from %0d requests, covering every level", n_results,
			n_requests);
		$display("boundary, the out-of-range and zero cases, and a long output stall.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
